// File: rtl/crpc_pkg.sv
// shared types and constants for the color range pixel counter
package crpc_pkg;

  // channel and field widths
  localparam int CHAN_W     = 8;
  localparam int COLOUR_W   = 24;
  localparam int FIELD_W    = 24;
  localparam int RIDX_W     = 3;
  localparam int EXT_W      = 32;

  // defaults for the top level parameters
  localparam int DEF_MAX_RANGES = 6;
  localparam int DEF_COUNT_BITS = 24;

  // reference colour registers
  localparam int NUM_COLOURS  = 6;
  localparam int COLOUR_IDX_W = 3;

  // configuration port
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 24;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_VARIATION   = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_RANGE_COUNT = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_COLOUR0     = 4'd2;

  // register reset values
  localparam logic [CHAN_W-1:0] VARIATION_RST   = 8'd10;
  localparam logic [RIDX_W-1:0] RANGE_COUNT_RST = 3'd1;

  localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hff;

  // one pixel
  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              frame_end;
  } pixel_t;

  // one per-range report
  typedef struct packed {
    logic [RIDX_W-1:0]  range_index;
    logic [FIELD_W-1:0] match_count;
    logic [FIELD_W-1:0] coloured_count;
    logic               last_report;
  } report_t;

  // inclusive window test on one channel, bounds clamped to 0..255
  function automatic logic chan_in(input logic [CHAN_W-1:0] px,
                                   input logic [CHAN_W-1:0] ref_val,
                                   input logic [CHAN_W-2:0] half);
    logic [CHAN_W-1:0] lo;
    logic [CHAN_W:0]   hi;
    lo = (ref_val > {1'b0, half}) ? ref_val - {1'b0, half} : '0;
    hi = {1'b0, ref_val} + {2'b00, half};
    return (px >= lo) && ({1'b0, px} <= hi);
  endfunction

endpackage

// File: rtl/color_range_pixel_counter.sv
// top level of the color range pixel counter
//
// Usage:
//  - pixel channel (pixel_valid/pixel_ready/pixel) takes one RGB pixel per
//    cycle while ready; frame_end marks the last pixel of a frame.
//  - report channel (report_valid/report_ready/report) returns one report per
//    active range after each frame end, range 0 first, last_report on the last.
//  - cfg channel writes variation, range_count and the six reference colours;
//    it is always ready; write it only while the block is idle (not enforced).
// Reports: a frame-end pixel passes through the input register and then loads
//  the report buffer; reports leave one per cycle while report_ready is high.
// Throughput: one pixel per cycle. Counts are copied into a report buffer at
//  frame end so the next frame counts while reports drain; a second frame end
//  waits in the input register until the buffer has sent its last report.
// Reset: counters clear, variation resets to 10, range_count to 1, colours
//  to 0, the input register and report buffer empty.
// Stall: while report_ready is low the current report holds; pixels keep
//  being counted until a new frame end needs the buffer.
module color_range_pixel_counter
  import crpc_pkg::*;
#(
  parameter int MAX_RANGES = DEF_MAX_RANGES,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   pixel_valid,
  output logic                   pixel_ready,
  input  pixel_t                 pixel,
  output logic                   report_valid,
  input  logic                   report_ready,
  output report_t                report,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [RIDX_W-1:0]     MAX_R   = RIDX_W'(MAX_RANGES);

  // configuration registers
  logic [CHAN_W-1:0]   variation;
  logic [RIDX_W-1:0]   range_count;
  logic [COLOUR_W-1:0] colour [NUM_COLOURS];

  // input register
  logic   in_valid;
  pixel_t in_pix;

  // live counters
  logic [COUNT_BITS-1:0] match_cnt [MAX_RANGES];
  logic [COUNT_BITS-1:0] nonwhite;

  // report buffer
  logic                  buf_busy;
  logic [RIDX_W-1:0]     buf_idx;
  logic [RIDX_W-1:0]     buf_n;
  logic [COUNT_BITS-1:0] buf_match [MAX_RANGES];
  logic [COUNT_BITS-1:0] buf_nonwhite;

  // datapath signals
  logic                  white;
  logic [CHAN_W-1:0]     px_red;
  logic [CHAN_W-1:0]     px_blue;
  logic [CHAN_W-2:0]     half;
  logic [RIDX_W-1:0]     active;
  logic                  buf_pop;
  logic                  buf_done;
  logic                  adv;
  logic [COUNT_BITS-1:0] nonwhite_next;
  logic [COUNT_BITS-1:0] match_next [MAX_RANGES];
  logic [COUNT_BITS-1:0] sel_match;
  logic [EXT_W-1:0]      sel_ext;
  logic [EXT_W-1:0]      nw_ext;

  // configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      variation   <= VARIATION_RST;
      range_count <= RANGE_COUNT_RST;
      for (int i = 0; i < NUM_COLOURS; i++) begin
        colour[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_VARIATION:   variation   <= cfg_data[CHAN_W-1:0];
        REG_RANGE_COUNT: range_count <= cfg_data[RIDX_W-1:0];
        default: begin
          if (cfg_index >= REG_COLOUR0 &&
              cfg_index < REG_COLOUR0 + CFG_INDEX_W'(NUM_COLOURS)) begin
            colour[COLOUR_IDX_W'(cfg_index - REG_COLOUR0)] <= cfg_data;
          end
        end
      endcase
    end
  end

  // report buffer drain and input register advance
  assign buf_pop  = buf_busy && report_ready;
  assign buf_done = buf_pop && (buf_idx + 1'b1 == buf_n);
  assign adv      = in_valid && (!in_pix.frame_end || !buf_busy || buf_done);
  assign pixel_ready = !in_valid || adv;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (pixel_ready) begin
      in_valid <= pixel_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pixel_ready && pixel_valid) begin
      in_pix <= pixel;
    end
  end

  // white replacement and active range count
  assign white   = (in_pix.red == CHAN_MAX) && (in_pix.green == CHAN_MAX) &&
                   (in_pix.blue == CHAN_MAX);
  assign px_red  = white ? '0 : in_pix.red;
  assign px_blue = white ? '0 : in_pix.blue;
  assign half    = variation[CHAN_W-1:1];
  assign active  = (range_count > MAX_R) ? MAX_R : range_count;

  // next counter values with saturation
  always_comb begin
    nonwhite_next = nonwhite;
    if (!white && nonwhite != CNT_MAX) begin
      nonwhite_next = nonwhite + 1'b1;
    end
    for (int k = 0; k < MAX_RANGES; k++) begin
      match_next[k] = match_cnt[k];
      if ((RIDX_W'(k) < active) && match_cnt[k] != CNT_MAX &&
          chan_in(px_red, colour[k][23:16], half) &&
          chan_in(in_pix.green, colour[k][15:8], half) &&
          chan_in(px_blue, colour[k][7:0], half)) begin
        match_next[k] = match_cnt[k] + 1'b1;
      end
    end
  end

  // live counters, cleared on frame end
  always_ff @(posedge clk) begin
    if (rst) begin
      nonwhite <= '0;
      for (int k = 0; k < MAX_RANGES; k++) begin
        match_cnt[k] <= '0;
      end
    end else if (adv) begin
      if (in_pix.frame_end) begin
        nonwhite <= '0;
        for (int k = 0; k < MAX_RANGES; k++) begin
          match_cnt[k] <= '0;
        end
      end else begin
        nonwhite <= nonwhite_next;
        for (int k = 0; k < MAX_RANGES; k++) begin
          match_cnt[k] <= match_next[k];
        end
      end
    end
  end

  // report buffer control
  always_ff @(posedge clk) begin
    if (rst) begin
      buf_busy <= 1'b0;
      buf_idx  <= '0;
      buf_n    <= '0;
    end else begin
      if (buf_pop) begin
        if (buf_done) begin
          buf_busy <= 1'b0;
        end else begin
          buf_idx <= buf_idx + 1'b1;
        end
      end
      if (adv && in_pix.frame_end && active != '0) begin
        buf_busy <= 1'b1;
        buf_idx  <= '0;
        buf_n    <= active;
      end
    end
  end

  // report buffer payload
  always_ff @(posedge clk) begin
    if (adv && in_pix.frame_end) begin
      buf_nonwhite <= nonwhite_next;
      for (int k = 0; k < MAX_RANGES; k++) begin
        buf_match[k] <= match_next[k];
      end
    end
  end

  // report output
  always_comb begin
    sel_match = '0;
    for (int k = 0; k < MAX_RANGES; k++) begin
      if (buf_idx == RIDX_W'(k)) begin
        sel_match = buf_match[k];
      end
    end
  end

  assign sel_ext = EXT_W'(sel_match);
  assign nw_ext  = EXT_W'(buf_nonwhite);

  assign report_valid          = buf_busy;
  assign report.range_index    = buf_idx;
  assign report.match_count    = sel_ext[FIELD_W-1:0];
  assign report.coloured_count = nw_ext[FIELD_W-1:0];
  assign report.last_report    = (buf_idx + 1'b1 == buf_n);

  // checks
  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    buf_busy |-> (buf_idx < buf_n && buf_n <= MAX_R))
    else $error("report index beyond active range count");

  a_buf_load: assert property (@(posedge clk) disable iff (rst)
    (adv && in_pix.frame_end && active != '0) |=> (buf_busy && buf_idx == '0))
    else $error("frame end did not load report buffer");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    (adv && in_pix.frame_end) |=> (nonwhite == '0))
    else $error("coloured count not cleared after frame end");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !pixel_ready |-> (in_valid && in_pix.frame_end && buf_busy))
    else $error("pixel input stalled without a pending frame end");

endmodule

// File: tb/tb.sv
// testbench for the color range pixel counter: directed cases, then random frames
module tb;
  import crpc_pkg::*;

  localparam int RANGES       = DEF_MAX_RANGES;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int IDLE_PCT     = 11;
  localparam int PHASE_PIXELS = 45;
  localparam int NUM_PHASES   = 9;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_FIRST = REG_COLOUR0 + CFG_INDEX_W'(NUM_COLOURS);
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_LAST  = '1;
  localparam logic [FIELD_W-1:0]     COUNT_FULL       = '1;
  localparam logic [COLOUR_W-1:0]    PURE_GREEN       = 24'h00ff00;

  // clock, reset and block ports
  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   pixel_valid = 1'b0;
  logic                   pixel_ready;
  pixel_t                 pixel = '0;
  logic                   report_valid;
  logic                   report_ready = 1'b0;
  report_t                report;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // predictor copy of registers and counters
  logic [CHAN_W-1:0]   tol_width;
  logic [RIDX_W-1:0]   active_sel;
  logic [COLOUR_W-1:0] ref_colour [NUM_COLOURS];
  logic [FIELD_W-1:0]  hit_count [RANGES];
  logic [FIELD_W-1:0]  nonwhite_count;
  report_t             pending_reports [$];

  // run bookkeeping
  bit quiet = 1'b0;
  int error_count  = 0;
  int pixels_sent  = 0;
  int frames_sent  = 0;
  int reports_seen = 0;
  int reg_writes   = 0;
  int cycle_count  = 0;

  color_range_pixel_counter dut (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_ready  (pixel_ready),
    .pixel        (pixel),
    .report_valid (report_valid),
    .report_ready (report_ready),
    .report       (report),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // cycle limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d reports still due", cycle_count,
               pending_reports.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic flag_mismatch(input string msg);
    error_count++;
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  // ---------------------------------------------------------------- predictor

  task automatic reset_model();
    tol_width      = VARIATION_RST;
    active_sel     = RANGE_COUNT_RST;
    nonwhite_count = '0;
    for (int k = 0; k < NUM_COLOURS; k++) ref_colour[k] = '0;
    for (int k = 0; k < RANGES; k++) hit_count[k] = '0;
  endtask

  function automatic bit in_window(input int px, input int centre, input int half);
    int lo;
    int hi;
    lo = (centre > half) ? centre - half : 0;
    hi = (centre + half > int'(CHAN_MAX)) ? int'(CHAN_MAX) : centre + half;
    return (px >= lo) && (px <= hi);
  endfunction

  // range_count above the number of ranges tests them all
  function automatic int live_ranges();
    return (active_sel > RANGES) ? RANGES : int'(active_sel);
  endfunction

  // count one accepted pixel and queue the frame reports on its last pixel
  task automatic tally_pixel(input pixel_t p);
    logic [CHAN_W-1:0]   r;
    logic [CHAN_W-1:0]   g;
    logic [CHAN_W-1:0]   b;
    logic [COLOUR_W-1:0] c;
    report_t             rpt;
    int                  half;
    int                  n;
    r    = p.red;
    g    = p.green;
    b    = p.blue;
    half = int'(tol_width >> 1);
    n    = live_ranges();
    // white turns into green and stays out of the coloured count
    if (r == CHAN_MAX && g == CHAN_MAX && b == CHAN_MAX) begin
      r = '0;
      b = '0;
    end else if (nonwhite_count != COUNT_FULL) begin
      nonwhite_count++;
    end
    for (int k = 0; k < n; k++) begin
      c = ref_colour[k];
      if (in_window(int'(r), int'(c[2*CHAN_W +: CHAN_W]), half) &&
          in_window(int'(g), int'(c[CHAN_W +: CHAN_W]), half) &&
          in_window(int'(b), int'(c[0 +: CHAN_W]), half) && hit_count[k] != COUNT_FULL)
        hit_count[k]++;
    end
    // frame end: counts include this pixel, then everything clears
    if (p.frame_end) begin
      for (int k = 0; k < n; k++) begin
        rpt.range_index    = RIDX_W'(k);
        rpt.match_count    = hit_count[k];
        rpt.coloured_count = nonwhite_count;
        rpt.last_report    = (k == n - 1);
        pending_reports.push_back(rpt);
      end
      for (int k = 0; k < RANGES; k++) hit_count[k] = '0;
      nonwhite_count = '0;
      frames_sent++;
    end
  endtask

  // ---------------------------------------------------------------- report checker

  always @(posedge clk) begin
    report_t want;
    if (!rst && report_valid && report_ready) begin
      reports_seen++;
      if (pending_reports.size() == 0) begin
        flag_mismatch($sformatf("report for range %0d with none due", report.range_index));
      end else begin
        want = pending_reports.pop_front();
        if (report.range_index !== want.range_index)
          flag_mismatch($sformatf("range_index %0d, wanted %0d",
                                  report.range_index, want.range_index));
        if (report.match_count !== want.match_count)
          flag_mismatch($sformatf("range %0d match_count %0d, wanted %0d",
                                  want.range_index, report.match_count, want.match_count));
        if (report.coloured_count !== want.coloured_count)
          flag_mismatch($sformatf("range %0d coloured_count %0d, wanted %0d", want.range_index,
                                  report.coloured_count, want.coloured_count));
        if (report.last_report !== want.last_report)
          flag_mismatch($sformatf("range %0d last_report %0b, wanted %0b",
                                  want.range_index, report.last_report, want.last_report));
      end
    end
    // random backpressure on the report side
    if (rst)
      report_ready <= 1'b0;
    else
      report_ready <= quiet ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
  end

  // ---------------------------------------------------------------- drivers

  function automatic pixel_t make_pixel(input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                                        input logic [CHAN_W-1:0] b, input logic last);
    pixel_t p;
    p.red       = r;
    p.green     = g;
    p.blue      = b;
    p.frame_end = last;
    return p;
  endfunction

  // one pixel transfer; valid stays up so the next pixel can follow at once
  task automatic send_pixel(input pixel_t p);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      pixel_valid <= 1'b0;
      @(posedge clk);
    end
    pixel_valid <= 1'b1;
    pixel       <= p;
    @(posedge clk);
    while (!pixel_ready) @(posedge clk);
    tally_pixel(p);
    pixels_sent++;
  endtask

  // drop valid and wait until the block has nothing left to report
  task automatic settle();
    pixel_valid <= 1'b0;
    @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one register transfer, applied to the predictor on acceptance
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    reg_writes++;
    if (idx == REG_VARIATION)
      tol_width = data[CHAN_W-1:0];
    else if (idx == REG_RANGE_COUNT)
      active_sel = data[RIDX_W-1:0];
    else if (idx >= REG_COLOUR0 && idx < REG_UNUSED_FIRST)
      ref_colour[COLOUR_IDX_W'(idx - REG_COLOUR0)] = data[COLOUR_W-1:0];
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------- directed tests

  // defaults after reset: half width 5 around black, one range
  task automatic test_reset_defaults();
    send_pixel(make_pixel(8'd5, 8'd5, 8'd5, 1'b0));
    send_pixel(make_pixel(8'd6, 8'd0, 8'd0, 1'b0));
    send_pixel(make_pixel(CHAN_MAX, CHAN_MAX, CHAN_MAX, 1'b0));
    send_pixel(make_pixel(8'd0, 8'd0, 8'd0, 1'b1));
    settle();
  endtask

  // white counts as green for matching but not for the coloured count
  task automatic test_white_to_green();
    write_reg(REG_VARIATION, '0);
    write_reg(REG_RANGE_COUNT, 24'd2);
    write_reg(REG_COLOUR0, PURE_GREEN);
    write_reg(REG_COLOUR0 + CFG_INDEX_W'(1), '1);
    send_pixel(make_pixel(CHAN_MAX, CHAN_MAX, CHAN_MAX, 1'b0));
    send_pixel(make_pixel(8'd0, CHAN_MAX, 8'd0, 1'b0));
    send_pixel(make_pixel(CHAN_MAX, CHAN_MAX, 8'd254, 1'b1));
    settle();
  endtask

  // window edges, clamping at both ends, widest tolerance
  task automatic test_window_bounds();
    write_reg(REG_VARIATION, 24'd255);
    write_reg(REG_RANGE_COUNT, 24'd3);
    write_reg(REG_COLOUR0, '0);
    write_reg(REG_COLOUR0 + CFG_INDEX_W'(2), 24'h808080);
    send_pixel(make_pixel(8'd127, 8'd127, 8'd127, 1'b0));
    send_pixel(make_pixel(8'd128, 8'd128, 8'd128, 1'b0));
    send_pixel(make_pixel(8'd0, 8'd0, 8'd0, 1'b0));
    send_pixel(make_pixel(CHAN_MAX, CHAN_MAX, CHAN_MAX, 1'b1));
    settle();
    // half width 10 around (10,110,245): just inside and just outside
    write_reg(REG_VARIATION, 24'd21);
    write_reg(REG_COLOUR0, 24'h0a6ef5);
    send_pixel(make_pixel(8'd0, 8'd100, CHAN_MAX, 1'b0));
    send_pixel(make_pixel(8'd20, 8'd120, 8'd235, 1'b0));
    send_pixel(make_pixel(8'd21, 8'd110, 8'd245, 1'b0));
    send_pixel(make_pixel(8'd10, 8'd99, 8'd245, 1'b0));
    send_pixel(make_pixel(8'd10, 8'd110, 8'd234, 1'b1));
    settle();
  endtask

  // no active range gives no reports yet clears; seven means all six
  task automatic test_range_count_limits();
    write_reg(REG_RANGE_COUNT, '0);
    send_pixel(make_pixel(8'd1, 8'd2, 8'd3, 1'b0));
    send_pixel(make_pixel(8'd4, 8'd5, 8'd6, 1'b1));
    settle();
    write_reg(REG_RANGE_COUNT, 24'hfffff7);
    send_pixel(make_pixel(8'd0, 8'd0, 8'd0, 1'b1));
    settle();
  endtask

  // writes past the colour registers must not disturb anything
  task automatic test_unused_index();
    write_reg(REG_UNUSED_FIRST, '1);
    write_reg(REG_UNUSED_LAST, 24'h123456);
    send_pixel(make_pixel(8'd10, 8'd110, 8'd245, 1'b1));
    settle();
  endtask

  // ---------------------------------------------------------------- random test

  function automatic logic [CHAN_W-1:0] near(input logic [CHAN_W-1:0] centre, input int half);
    int v;
    v = int'(centre) + int'($urandom_range(2 * half + 4)) - half - 2;
    if (v < 0) v = 0;
    if (v > int'(CHAN_MAX)) v = int'(CHAN_MAX);
    return CHAN_W'(v);
  endfunction

  // mostly pixels around an active colour, plus white, extremes and noise
  function automatic pixel_t pick_pixel();
    pixel_t              p;
    logic [COLOUR_W-1:0] c;
    int                  n;
    int                  half;
    int                  mode;
    p    = pixel_t'($urandom);
    n    = live_ranges();
    half = int'(tol_width >> 1);
    mode = $urandom_range(99);
    if (mode < 55 && n > 0) begin
      c       = ref_colour[$urandom_range(n - 1)];
      p.red   = near(c[2*CHAN_W +: CHAN_W], half);
      p.green = near(c[CHAN_W +: CHAN_W], half);
      p.blue  = near(c[0 +: CHAN_W], half);
    end else if (mode < 65) begin
      {p.red, p.green, p.blue} = '1;
    end else if (mode < 75) begin
      p.red   = $urandom_range(1) ? CHAN_MAX : '0;
      p.green = $urandom_range(1) ? CHAN_MAX : '0;
      p.blue  = $urandom_range(1) ? CHAN_MAX : '0;
    end
    p.frame_end = 1'b0;
    return p;
  endfunction

  // new settings for every register, with junk in the unused data bits
  task automatic shuffle_config();
    logic [CFG_DATA_W-1:0] junk;
    logic [CHAN_W-1:0]     tol;
    logic [RIDX_W-1:0]     sel;
    logic [COLOUR_W-1:0]   c;
    junk = CFG_DATA_W'($urandom);
    case ($urandom_range(5))
      0: tol = '0;
      1: tol = 8'd1;
      2: tol = '1;
      3: tol = CHAN_W'($urandom_range(2, 30));
      default: tol = CHAN_W'($urandom);
    endcase
    case ($urandom_range(15))
      0: sel = '0;
      1: sel = '1;
      default: sel = RIDX_W'($urandom_range(1, RANGES));
    endcase
    write_reg(REG_VARIATION, {junk[CFG_DATA_W-1:CHAN_W], tol});
    write_reg(REG_RANGE_COUNT, {junk[CFG_DATA_W-1:RIDX_W], sel});
    for (int k = 0; k < NUM_COLOURS; k++) begin
      case ($urandom_range(7))
        0: c = '0;
        1: c = '1;
        2: c = PURE_GREEN;
        default: c = COLOUR_W'($urandom);
      endcase
      write_reg(REG_COLOUR0 + CFG_INDEX_W'(k), c);
    end
    if ($urandom_range(3) == 0)
      write_reg(REG_UNUSED_FIRST + CFG_INDEX_W'($urandom_range(7)), CFG_DATA_W'($urandom));
  endtask

  // frames of random length under one random setting
  task automatic random_phase(input int budget);
    pixel_t p;
    int     len;
    shuffle_config();
    while (budget > 0) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
      if (len > budget) len = budget;
      for (int i = 0; i < len; i++) begin
        p           = pick_pixel();
        p.frame_end = (i == len - 1);
        send_pixel(p);
      end
      budget -= len;
    end
    settle();
  endtask

  // one phase runs with no idling on either side
  task automatic test_random_frames();
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      quiet = (ph == NUM_PHASES / 2);
      random_phase(PHASE_PIXELS);
    end
    quiet = 1'b0;
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    reset_model();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_white_to_green();
    test_window_bounds();
    test_range_count_limits();
    test_unused_index();
    test_random_frames();
    if (pending_reports.size() != 0)
      flag_mismatch($sformatf("%0d reports never arrived", pending_reports.size()));
    $display("summary: %0d pixels in %0d frames, %0d reports compared",
             pixels_sent, frames_sent, reports_seen);
    $display("summary: %0d register writes over directed and random settings", reg_writes);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", error_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
